/* design/assert_macros.svh */
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* design/ffcu_pkg.sv */
package ffcu_pkg;
  typedef enum logic [2:0] {
    ACT_F32_F16  = 3'd0,
    ACT_F16_F32  = 3'd1,
    ACT_F32_BF16 = 3'd2,
    ACT_BF16_F32 = 3'd3,
    ACT_F32_FP4  = 3'd4,
    ACT_FP4_F32  = 3'd5
  } action_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] operand;
  } item_t;

  function automatic logic [31:0] fp4_mag(input logic [2:0] c);
    logic [31:0] v;
    unique case (c)
      3'd0: v = 32'h00000000;
      3'd1: v = 32'h3F000000;
      3'd2: v = 32'h3F800000;
      3'd3: v = 32'h3FC00000;
      3'd4: v = 32'h40000000;
      3'd5: v = 32'h40400000;
      3'd6: v = 32'h40800000;
      default: v = 32'h40C00000;
    endcase
    return v;
  endfunction
endpackage

/* design/ffcu_narrow.sv */
module ffcu_narrow (
  input  logic [31:0] operand,
  output logic [15:0] f16,
  output logic [15:0] bf16,
  output logic [3:0]  fp4
);
  import ffcu_pkg::*;

  logic        s;
  logic [7:0]  ex;
  logic [22:0] man;
  logic [8:0]  e;
  logic [4:0]  sh;
  logic [23:0] full, kept, rem, half, mask;
  logic [15:0] hn, hs;
  logic [12:0] rn;
  logic [31:0] a, bsum;
  logic [2:0]  c;

  always_comb begin
    s    = operand[31];
    ex   = operand[30:23];
    man  = operand[22:0];
    e    = {1'b0, ex} - 9'd112;
    full = {1'b1, man};
    sh   = 5'd14 - e[4:0];
    kept = full >> sh;
    mask = (24'd1 << sh) - 24'd1;
    rem  = full & mask;
    half = 24'd1 << (sh - 5'd1);
    hs   = {s, 15'd0} | kept[15:0];
    if (rem > half || (rem == half && kept[0])) hs = hs + 16'd1;
    rn = man[12:0];
    hn = {s, e[4:0], man[22:13]};
    if (rn > 13'h1000 || (rn == 13'h1000 && hn[0])) hn = hn + 16'd1;
    if (ex == 8'hff) f16 = {s, 15'h7c00} | (man != 0 ? 16'h0200 : 16'h0);
    else if (ex >= 8'd143) f16 = {s, 15'h7c00};
    else if (ex > 8'd112) f16 = hn;
    else if (ex < 8'd102) f16 = {s, 15'd0};
    else f16 = hs;

    bsum = operand + 32'h00007fff + {31'd0, operand[16]};
    if (ex == 8'hff && man != 0) bf16 = operand[31:16] | 16'h0040;
    else bf16 = bsum[31:16];

    a = {1'b0, operand[30:0]};
    if (a <= 32'h3E800000) c = 3'd0;
    else if (a < 32'h3F400000) c = 3'd1;
    else if (a <= 32'h3FA00000) c = 3'd2;
    else if (a < 32'h3FE00000) c = 3'd3;
    else if (a <= 32'h40200000) c = 3'd4;
    else if (a < 32'h40600000) c = 3'd5;
    else if (a <= 32'h40A00000) c = 3'd6;
    else c = 3'd7;
    fp4 = (a > 32'h7f800000) ? 4'd0 : {s, c};
  end
endmodule

/* design/ffcu_widen.sv */
module ffcu_widen (
  input  logic [31:0] operand,
  output logic [31:0] from_f16,
  output logic [31:0] from_fp4
);
  import ffcu_pkg::*;

  logic       s;
  logic [4:0] ex;
  logic [9:0] man, nm;
  logic [7:0] e;
  logic [3:0] lz;

  always_comb begin
    s  = operand[15];
    ex = operand[14:10];
    man = operand[9:0];
    lz = 4'd0;
    for (int i = 0; i < 10; i++) if (man[i]) lz = 4'(9 - i);
    nm = (man << (lz + 4'd1));
    e  = 8'd112 - {4'd0, lz};
    if (ex == 5'd0) begin
      if (man == 10'd0) from_f16 = {s, 31'd0};
      else from_f16 = {s, e, nm, 13'd0};
    end else if (ex == 5'h1f) from_f16 = {s, 8'hff, man, 13'd0};
    else from_f16 = {s, 8'({3'd0, ex} + 8'd112), man, 13'd0};
    from_fp4 = {operand[3], 31'd0} | fp4_mag(operand[2:0]);
  end
endmodule

/* design/float_format_cast_unit_top.sv */
// Channel  | Ports                         | Beat
// input    | start, busy, in_action/operand| start && !busy
// result   | out_valid, out_converted      | out_valid, one cycle
// Operands are registered in item_r, converted, then the result register
// res_r drives the outputs. An item may start every cycle; busy is tied low.
// Synchronous active-low reset clears the valid flags. No stalls.
`include "assert_macros.svh"
module float_format_cast_unit_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_action,
  input  logic [31:0] in_operand,
  output logic        out_valid,
  output logic [31:0] out_converted
);
  import ffcu_pkg::*;

  item_t       item_r;
  logic        v_r, ov_r;
  logic [31:0] res_r, res_nxt;
  logic [15:0] f16, bf16;
  logic [3:0]  fp4;
  logic [31:0] w16, w4;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      v_r  <= start;
      ov_r <= v_r;
    end
    item_r <= '{action: in_action, operand: in_operand};
    res_r  <= res_nxt;
  end

  ffcu_narrow u_narrow (.operand(item_r.operand), .f16(f16), .bf16(bf16), .fp4(fp4));
  ffcu_widen  u_widen  (.operand(item_r.operand), .from_f16(w16), .from_fp4(w4));

  always_comb begin
    unique case (item_r.action)
      ACT_F32_F16:  res_nxt = {16'd0, f16};
      ACT_F16_F32:  res_nxt = w16;
      ACT_F32_BF16: res_nxt = {16'd0, bf16};
      ACT_BF16_F32: res_nxt = {item_r.operand[15:0], 16'd0};
      ACT_F32_FP4:  res_nxt = {28'd0, fp4};
      ACT_FP4_F32:  res_nxt = w4;
      default:      res_nxt = 32'd0;
    endcase
  end

  assign out_valid     = ov_r;
  assign out_converted = res_r;

  `ASSERT_NEXT(a_lat, clk, rst_n, v_r, out_valid)
  `ASSERT_IMPL(a_fp4_top, clk, rst_n, v_r && item_r.action == ACT_F32_FP4, res_nxt[31:4] == 28'd0)
  `ASSERT_IMPL(a_f16_top, clk, rst_n, v_r && item_r.action == ACT_F32_F16, res_nxt[31:16] == 16'd0)
endmodule
